### design/upwind_face_flux_assert.svh
// assertion macros for the upwind face flux block
// used by the checker; needs a clock and an active-low reset in scope
`ifndef UPWIND_FACE_FLUX_ASSERT_SVH
`define UPWIND_FACE_FLUX_ASSERT_SVH

// same-cycle implication, held off during reset
`define UFF_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("upwind_face_flux: check failed");

// next-cycle implication, held off during reset
`define UFF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("upwind_face_flux: check failed");

`endif

### design/uff_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and coefficient helpers for the upwind face flux block
// no dependencies
package uff_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;

    // stencil order codes
    localparam int ORDER_W = 2;
    localparam logic [ORDER_W-1:0] ORD_FIRST   = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_THIRD   = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_SEVENTH = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPWIND_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOBILITY     = 2'd1;

    // seventh order weights with the common factor 12 taken out; 5040 / 12 = 420
    localparam int SEV_WEIGHT [7] = '{-3, 25, -101, 319, 214, -38, 4};
    localparam int SEV_HALF = 210;
    // 420 = 4 * 105: the low two bits are dropped, then divide by 105
    localparam int SEV_DIV  = 105;

    // control that travels with each word down the pipe
    typedef struct packed {
        logic               valid;
        logic [ORDER_W-1:0] order;
    } ctl_t;

    // third order coefficient k, rounded half away from zero at fb fraction bits
    function automatic logic signed [63:0] third_coef(input int k, input int fb);
        logic [127:0] mag;
        logic [127:0] q;
        case (k)
            0:       mag = 128'd213933;
            1:       mag = 128'd927865;
            default: mag = 128'd286067;
        endcase
        q = ((mag << fb) + 128'd500000) / 128'd1000000;
        return (k == 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

endpackage

### design/uff_face_if.sv
`timescale 1ns / 1ps
// channel interfaces: stencil words in, flux words out
// depends on uff_pkg
interface uff_face_if import uff_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] vel_left;
    logic signed [DATA_WIDTH-1:0] vel_right;
    logic signed [DATA_WIDTH-1:0] phi_m3;
    logic signed [DATA_WIDTH-1:0] phi_m2;
    logic signed [DATA_WIDTH-1:0] phi_m1;
    logic signed [DATA_WIDTH-1:0] phi_left;
    logic signed [DATA_WIDTH-1:0] phi_right;
    logic signed [DATA_WIDTH-1:0] phi_p1;
    logic signed [DATA_WIDTH-1:0] phi_p2;
    logic signed [DATA_WIDTH-1:0] phi_p3;
    logic signed [DATA_WIDTH-1:0] mu_left;
    logic signed [DATA_WIDTH-1:0] mu_right;

    modport source (
        output valid, vel_left, vel_right, phi_m3, phi_m2, phi_m1, phi_left,
               phi_right, phi_p1, phi_p2, phi_p3, mu_left, mu_right,
        input  ready
    );
    modport sink (
        input  valid, vel_left, vel_right, phi_m3, phi_m2, phi_m1, phi_left,
               phi_right, phi_p1, phi_p2, phi_p3, mu_left, mu_right,
        output ready
    );
endinterface

interface uff_flux_if import uff_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] face_flux;
    logic                         saturated;

    modport source (output valid, face_flux, saturated, input ready);
    modport sink (input valid, face_flux, saturated, output ready);
endinterface

### design/uff_stencil.sv
`timescale 1ns / 1ps
// stages 1-2: face velocity, upwind operand pick, stencil products, diffusive product
// depends on uff_pkg
module uff_stencil import uff_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int W  = DATA_WIDTH,
    localparam int CW = FRAC_BITS + 1,
    localparam int TW = CW + W,
    localparam int SW = W + 10,
    localparam int DW = 2 * W + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [ORDER_W-1:0]   order,
    input  logic [W-2:0]         mobility,
    input  logic signed [W-1:0]  vel_left,
    input  logic signed [W-1:0]  vel_right,
    input  logic signed [W-1:0]  phi_m3,
    input  logic signed [W-1:0]  phi_m2,
    input  logic signed [W-1:0]  phi_m1,
    input  logic signed [W-1:0]  phi_left,
    input  logic signed [W-1:0]  phi_right,
    input  logic signed [W-1:0]  phi_p1,
    input  logic signed [W-1:0]  phi_p2,
    input  logic signed [W-1:0]  phi_p3,
    input  logic signed [W-1:0]  mu_left,
    input  logic signed [W-1:0]  mu_right,
    output ctl_t                 ctl,
    output logic signed [W-1:0]  u,
    output logic signed [TW-1:0] tprod [3],
    output logic signed [SW-1:0] acc7,
    output logic signed [W-1:0]  phi1,
    output logic signed [DW-1:0] dif
);

    localparam logic signed [CW-1:0] COEF [3] = '{
        CW'(third_coef(0, FRAC_BITS)),
        CW'(third_coef(1, FRAC_BITS)),
        CW'(third_coef(2, FRAC_BITS))
    };

    ctl_t                ctl1_reg, ctl2_reg;
    logic signed [W:0]   vsum;
    logic signed [W-1:0] u1_next, u1_reg, u2_reg;
    logic signed [W-1:0] p_next [7];
    logic signed [W-1:0] p_reg [7];
    logic signed [W:0]   dmu_next, dmu_reg;
    logic signed [TW-1:0] t_next [3];
    logic signed [TW-1:0] t_reg [3];
    logic signed [SW-1:0] acc7_next, acc7_reg;
    logic signed [W-1:0]  phi1_reg;
    logic signed [DW-1:0] dif_next, dif_reg;

    // face velocity is the floored mean; its sign picks the upwind side
    always_comb
    begin
        vsum    = {vel_left[W-1], vel_left} + {vel_right[W-1], vel_right};
        u1_next = vsum[W:1];
        if (!vsum[W])
        begin
            p_next = '{phi_m3, phi_m2, phi_m1, phi_left, phi_right, phi_p1, phi_p2};
        end
        else
        begin
            p_next = '{phi_p3, phi_p2, phi_p1, phi_right, phi_left, phi_m1, phi_m2};
        end
        dmu_next = {mu_right[W-1], mu_right} - {mu_left[W-1], mu_left};
    end

    // stage 1 and stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= '{valid: in_valid, order: order};
            ctl2_reg <= ctl1_reg;
        end
    end

    // stage 1 data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg  <= u1_next;
            p_reg   <= p_next;
            dmu_reg <= dmu_next;
        end
    end

    // third order products, seventh order weighted sum, diffusive product
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_next[k] = TW'(COEF[k]) * TW'(p_reg[k+2]);
        end
        acc7_next = '0;
        for (int k = 0; k < 7; k++)
        begin
            acc7_next = acc7_next + SW'(p_reg[k]) * SW'(SEV_WEIGHT[k]);
        end
        dif_next = $signed(DW'({1'b0, mobility})) * DW'(dmu_reg);
    end

    // stage 2 data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u2_reg   <= u1_reg;
            t_reg    <= t_next;
            acc7_reg <= acc7_next;
            phi1_reg <= p_reg[3];
            dif_reg  <= dif_next;
        end
    end

    assign ctl   = ctl2_reg;
    assign u     = u2_reg;
    assign tprod = t_reg;
    assign acc7  = acc7_reg;
    assign phi1  = phi1_reg;
    assign dif   = dif_reg;

endmodule

### design/uff_phi.sv
`timescale 1ns / 1ps
// stages 3-5: third order rounding, seventh order divide by reciprocal, face value pick
// depends on uff_pkg
module uff_phi import uff_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int W  = DATA_WIDTH,
    localparam int TW = FRAC_BITS + 1 + W,
    localparam int SW = W + 10,
    localparam int DW = 2 * W + 1,
    localparam int PW = W + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ctl_t                 ctl_in,
    input  logic signed [W-1:0]  u_in,
    input  logic signed [TW-1:0] tprod [3],
    input  logic signed [SW-1:0] acc7,
    input  logic signed [W-1:0]  phi1,
    input  logic signed [DW-1:0] dif_in,
    output ctl_t                 ctl,
    output logic signed [W-1:0]  u,
    output logic signed [PW-1:0] phi_f,
    output logic signed [DW-1:0] dif
);

    localparam int M4W = SW - 2;
    localparam int H   = M4W / 2;
    localparam int HW  = M4W - H;
    localparam int RW  = W + 2;
    localparam int PRW = M4W + RW;
    localparam logic [127:0] ONE = 128'd1;
    localparam logic [RW-1:0] RECIP = RW'((ONE << M4W) / 128'd105);
    localparam logic [TW+1:0] HALF3 = (TW+2)'(ONE << (FRAC_BITS - 1));

    ctl_t ctl3_reg, ctl4_reg, ctl5_reg;
    logic signed [W-1:0]  u3_reg, u4_reg, u5_reg;
    logic signed [DW-1:0] dif3_reg, dif4_reg, dif5_reg;
    logic signed [W-1:0]  phi1_3_reg, phi1_4_reg;
    logic signed [TW+1:0] sum3;
    logic signed [PW-1:0] phi3_next, phi3_3_reg, phi3_4_reg;
    logic                 neg7_next, neg7_3_reg, neg7_4_reg;
    logic [SW-1:0]        mag7, m7;
    logic [M4W-1:0]       m4_next, m4_3_reg, m4_4_reg;
    logic [H+RW-1:0]      plo_next, plo_reg;
    logic [HW+RW-1:0]     phi_hi_next, phi_hi_reg;
    logic [PRW-1:0]       prod;
    logic [RW-1:0]        qest_next, qest_reg;
    logic [M4W-1:0]       qm, rem;
    logic [RW-1:0]        q7;
    logic signed [PW-1:0] phi7, phif_next, phif_reg;

    // control through stages 3 to 5
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    // stage 3: third order round, seventh order magnitude and split reciprocal product
    always_comb
    begin
        sum3 = (TW+2)'(tprod[0]) + (TW+2)'(tprod[1]) + (TW+2)'(tprod[2]) + $signed(HALF3);
        phi3_next = PW'(sum3 >>> FRAC_BITS);
        neg7_next = acc7[SW-1];
        mag7 = neg7_next ? SW'(-acc7) : SW'(acc7);
        m7 = mag7 + SW'(SEV_HALF);
        m4_next = m7[SW-1:2];
        plo_next = (H+RW)'(m4_next[H-1:0]) * (H+RW)'(RECIP);
        phi_hi_next = (HW+RW)'(m4_next[M4W-1:H]) * (HW+RW)'(RECIP);
    end

    // stage 4: quotient estimate, at most one low
    always_comb
    begin
        prod = (PRW'(phi_hi_reg) << H) + PRW'(plo_reg);
        qest_next = prod[PRW-1:M4W];
    end

    // stage 5: correct the quotient, apply sign, pick the face value
    always_comb
    begin
        qm   = M4W'(qest_reg) * M4W'(SEV_DIV);
        rem  = m4_4_reg - qm;
        q7   = qest_reg + RW'(rem >= M4W'(SEV_DIV));
        phi7 = neg7_4_reg ? -$signed(q7) : $signed(q7);
        case (ctl4_reg.order)
            ORD_THIRD:   phif_next = phi3_4_reg;
            ORD_SEVENTH: phif_next = phi7;
            default:     phif_next = PW'(phi1_4_reg);
        endcase
    end

    // data through stages 3 to 5
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u3_reg     <= u_in;
            dif3_reg   <= dif_in;
            phi1_3_reg <= phi1;
            phi3_3_reg <= phi3_next;
            neg7_3_reg <= neg7_next;
            m4_3_reg   <= m4_next;
            plo_reg    <= plo_next;
            phi_hi_reg <= phi_hi_next;

            u4_reg     <= u3_reg;
            dif4_reg   <= dif3_reg;
            phi1_4_reg <= phi1_3_reg;
            phi3_4_reg <= phi3_3_reg;
            neg7_4_reg <= neg7_3_reg;
            m4_4_reg   <= m4_3_reg;
            qest_reg   <= qest_next;

            u5_reg     <= u4_reg;
            dif5_reg   <= dif4_reg;
            phif_reg   <= phif_next;
        end
    end

    assign ctl   = ctl5_reg;
    assign u     = u5_reg;
    assign phi_f = phif_reg;
    assign dif   = dif5_reg;

endmodule

### design/uff_combine.sv
`timescale 1ns / 1ps
// stages 6-7: advective product, flux difference, rounding and saturation
// depends on uff_pkg
module uff_combine import uff_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int W  = DATA_WIDTH,
    localparam int DW = 2 * W + 1,
    localparam int PW = W + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ctl_t                 ctl_in,
    input  logic signed [W-1:0]  u,
    input  logic signed [PW-1:0] phi_f,
    input  logic signed [DW-1:0] dif,
    output logic                 out_valid,
    output logic signed [W-1:0]  face_flux,
    output logic                 saturated
);

    localparam int AW   = W + PW;
    localparam int TOTW = AW + 1;
    localparam logic [127:0] ONE = 128'd1;
    localparam logic [TOTW-1:0] HALF = TOTW'(ONE << (FRAC_BITS - 1));
    localparam logic [W-1:0] FLUX_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] FLUX_MIN = {1'b1, {(W-1){1'b0}}};

    logic                   v6_reg, v7_reg;
    logic signed [AW-1:0]   adv_next, adv_reg;
    logic signed [DW-1:0]   dif6_reg;
    logic signed [TOTW-1:0] total, rs;
    logic [TOTW-W:0]        top_bits;
    logic                   sat_next, sat_reg;
    logic signed [W-1:0]    flux_next, flux_reg;

    // valid bits for stages 6 and 7
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= ctl_in.valid;
            v7_reg <= v6_reg;
        end
    end

    // advective term u * phi_f
    assign adv_next = AW'(u) * AW'(phi_f);

    // round half up to the output grid, clip to the data range
    always_comb
    begin
        total     = TOTW'(adv_reg) - TOTW'(dif6_reg) + $signed(HALF);
        rs        = total >>> FRAC_BITS;
        top_bits  = rs[TOTW-1:W-1];
        sat_next  = !((&top_bits) || !(|top_bits));
        if (sat_next)
        begin
            flux_next = rs[TOTW-1] ? $signed(FLUX_MIN) : $signed(FLUX_MAX);
        end
        else
        begin
            flux_next = rs[W-1:0];
        end
    end

    // stage 6 and output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adv_reg  <= adv_next;
            dif6_reg <= dif;
            flux_reg <= flux_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = v7_reg;
    assign face_flux = flux_reg;
    assign saturated = sat_reg;

endmodule

### design/upwind_face_flux.sv
`timescale 1ns / 1ps
// Upwind face flux, seven register stages. A word accepted at a clock edge reaches the
// result port from the last stage register; one word per cycle is taken and delivered
// while no result is stalled. The whole pipe advances together; it holds only while a
// result waits to be taken. Reset (rst_n, asynchronous, active low) empties the pipe
// and clears upwind_order and mobility to zero.
module upwind_face_flux import uff_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    uff_face_if.sink              face,
    uff_flux_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [DATA_WIDTH-2:0] cfg_wdata
);

    localparam int W  = DATA_WIDTH;
    localparam int TW = FRAC_BITS + 1 + W;
    localparam int SW = W + 10;
    localparam int DW = 2 * W + 1;
    localparam int PW = W + 2;

    logic [ORDER_W-1:0] order_reg;
    logic [W-2:0]       mobility_reg;
    logic               en;

    ctl_t                 ctl_s2, ctl_s5;
    logic signed [W-1:0]  u_s2, u_s5;
    logic signed [TW-1:0] tprod_s2 [3];
    logic signed [SW-1:0] acc7_s2;
    logic signed [W-1:0]  phi1_s2;
    logic signed [DW-1:0] dif_s2, dif_s5;
    logic signed [PW-1:0] phif_s5;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg    <= ORD_FIRST;
            mobility_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_UPWIND_ORDER: order_reg    <= cfg_wdata[ORDER_W-1:0];
                CFG_MOBILITY:     mobility_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // pipe advances unless a finished word is stalled at the output
    assign en         = !result.valid || result.ready;
    assign face.ready = en;

    uff_stencil #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_stencil (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (face.valid),
        .order     (order_reg),
        .mobility  (mobility_reg),
        .vel_left  (face.vel_left),
        .vel_right (face.vel_right),
        .phi_m3    (face.phi_m3),
        .phi_m2    (face.phi_m2),
        .phi_m1    (face.phi_m1),
        .phi_left  (face.phi_left),
        .phi_right (face.phi_right),
        .phi_p1    (face.phi_p1),
        .phi_p2    (face.phi_p2),
        .phi_p3    (face.phi_p3),
        .mu_left   (face.mu_left),
        .mu_right  (face.mu_right),
        .ctl       (ctl_s2),
        .u         (u_s2),
        .tprod     (tprod_s2),
        .acc7      (acc7_s2),
        .phi1      (phi1_s2),
        .dif       (dif_s2)
    );

    uff_phi #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_phi (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (ctl_s2),
        .u_in   (u_s2),
        .tprod  (tprod_s2),
        .acc7   (acc7_s2),
        .phi1   (phi1_s2),
        .dif_in (dif_s2),
        .ctl    (ctl_s5),
        .u      (u_s5),
        .phi_f  (phif_s5),
        .dif    (dif_s5)
    );

    uff_combine #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_s5),
        .u         (u_s5),
        .phi_f     (phif_s5),
        .dif       (dif_s5),
        .out_valid (result.valid),
        .face_flux (result.face_flux),
        .saturated (result.saturated)
    );

endmodule

### design/upwind_face_flux_chk.sv
`timescale 1ns / 1ps
// port-level checker for upwind_face_flux, attached by bind
// depends on uff_pkg and upwind_face_flux_assert.svh
`include "upwind_face_flux_assert.svh"

module upwind_face_flux_chk import uff_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         face_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [DATA_WIDTH-1:0] res_flux,
    input logic                         res_sat
);

    localparam logic [DATA_WIDTH-1:0] FLUX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] FLUX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // a stalled result word holds
    `UFF_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_flux) && $stable(res_sat))
    // a stalled result blocks new words
    `UFF_ASSERT_NOW(a_stall_blocks, clk, rst_n, res_valid && !res_ready, !face_ready)
    // with nothing waiting at the output, input is always taken
    `UFF_ASSERT_NOW(a_free_ready, clk, rst_n, !res_valid || res_ready, face_ready)
    // a clipped flux sits at one end of the range
    `UFF_ASSERT_NOW(a_sat_limit, clk, rst_n, res_valid && res_sat, res_flux == FLUX_MAX || res_flux == FLUX_MIN)

endmodule

bind upwind_face_flux upwind_face_flux_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .face_ready (face.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_flux   (result.face_flux),
    .res_sat    (result.saturated)
);

### dv/upwind_face_flux_test.sv
`timescale 1ns / 1ps
// testbench for upwind_face_flux: corner and random stencil words checked against a scoreboard
// depends on uff_pkg, uff_face_if, uff_flux_if and the upwind_face_flux rtl
module upwind_face_flux_test;
    import uff_pkg::*;

    localparam int DW           = DATA_WIDTH_DEF;
    localparam int FB           = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_PHASE   = 4;

    // order code three behaves as first order; indexes two and three are unused
    localparam logic [ORDER_W-1:0]   ORD_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [DW-2:0]        MOB_MAX = '1;
    localparam logic [DW-2:0]        MOB_ONE = 31'd1 << FB;
    localparam logic signed [DW-1:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [127:0]  FLUX_MAX = 128'sd2147483647;
    localparam logic signed [127:0]  FLUX_MIN = -128'sd2147483648;

    typedef struct packed {
        logic signed [DW-1:0] vel_left;
        logic signed [DW-1:0] vel_right;
        logic signed [DW-1:0] phi_m3;
        logic signed [DW-1:0] phi_m2;
        logic signed [DW-1:0] phi_m1;
        logic signed [DW-1:0] phi_left;
        logic signed [DW-1:0] phi_right;
        logic signed [DW-1:0] phi_p1;
        logic signed [DW-1:0] phi_p2;
        logic signed [DW-1:0] phi_p3;
        logic signed [DW-1:0] mu_left;
        logic signed [DW-1:0] mu_right;
    } face_t;

    typedef struct packed {
        logic signed [DW-1:0] face_flux;
        logic                 saturated;
    } flux_t;

    // flux predictor with its own register copy and the queue of expected flux words
    class flux_scoreboard;
        logic [ORDER_W-1:0] cfg_order;
        logic [DW-2:0]      cfg_mob;
        flux_t              pending_flux [$];
        int                 errors;

        function new();
            cfg_order = ORD_FIRST;
            cfg_mob   = '0;
            errors    = 0;
        endfunction

        // third order weight k at FB fraction bits, rounded half away from zero
        function logic signed [127:0] third_weight(int k);
            logic [127:0] ppm;
            logic [127:0] scaled;
            case (k)
                0:       ppm = 213933;
                1:       ppm = 927865;
                default: ppm = 286067;
            endcase
            scaled = ((ppm << (FB + 1)) + 128'd1000000) / 128'd2000000;
            return (k == 0) ? -$signed(scaled) : $signed(scaled);
        endfunction

        // seventh order integer tap k, upwind side first
        function int seventh_tap(int k);
            case (k)
                0:       return -36;
                1:       return 300;
                2:       return -1212;
                3:       return 3828;
                4:       return 2568;
                5:       return -456;
                default: return 48;
            endcase
        endfunction

        function flux_t predict_flux(face_t w);
            logic signed [127:0] f [12];
            logic signed [127:0] u, acc, phi_f, mob, total, r;
            logic [127:0]        mag, quo;
            logic                upwind_right;
            int                  k;
            flux_t               res;
            f[0]  = $signed(w.vel_left);
            f[1]  = $signed(w.vel_right);
            f[2]  = $signed(w.phi_m3);
            f[3]  = $signed(w.phi_m2);
            f[4]  = $signed(w.phi_m1);
            f[5]  = $signed(w.phi_left);
            f[6]  = $signed(w.phi_right);
            f[7]  = $signed(w.phi_p1);
            f[8]  = $signed(w.phi_p2);
            f[9]  = $signed(w.phi_p3);
            f[10] = $signed(w.mu_left);
            f[11] = $signed(w.mu_right);
            // face velocity is the floored mean; zero keeps the left side upwind
            u = (f[0] + f[1]) >>> 1;
            upwind_right = u[127];
            acc = '0;
            case (cfg_order)
                ORD_THIRD:
                begin
                    if (upwind_right)
                        acc = third_weight(0) * f[7] + third_weight(1) * f[6]
                            + third_weight(2) * f[5];
                    else
                        acc = third_weight(0) * f[4] + third_weight(1) * f[5]
                            + third_weight(2) * f[6];
                    phi_f = ((acc >>> (FB - 1)) + 1) >>> 1;
                end
                ORD_SEVENTH:
                begin
                    for (k = 0; k < 7; k++)
                        acc += seventh_tap(k) * f[upwind_right ? 9 - k : 2 + k];
                    // divide by 7! with round half away from zero
                    mag   = acc[127] ? -acc : acc;
                    quo   = (mag + 128'd2520) / 128'd5040;
                    phi_f = acc[127] ? -$signed(quo) : $signed(quo);
                end
                default:
                    phi_f = upwind_right ? f[6] : f[5];
            endcase
            mob   = {{(128 - DW + 1){1'b0}}, cfg_mob};
            total = u * phi_f - mob * (f[11] - f[10]);
            r     = ((total >>> (FB - 1)) + 1) >>> 1;
            if (r > FLUX_MAX)
            begin
                res.face_flux = Q_MAX;
                res.saturated = 1'b1;
            end
            else if (r < FLUX_MIN)
            begin
                res.face_flux = Q_MIN;
                res.saturated = 1'b1;
            end
            else
            begin
                res.face_flux = r[DW-1:0];
                res.saturated = 1'b0;
            end
            return res;
        endfunction

        function void note_face(face_t w);
            pending_flux.push_back(predict_flux(w));
        endfunction

        function void check_flux(flux_t got);
            flux_t want;
            if (pending_flux.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected flux word %h sat %b", $time, got.face_flux,
                         got.saturated);
            end
            else
            begin
                want = pending_flux.pop_front();
                if (got.face_flux !== want.face_flux)
                begin
                    errors++;
                    $display("%0t: face_flux expected %h, got %h", $time, want.face_flux,
                             got.face_flux);
                end
                if (got.saturated !== want.saturated)
                begin
                    errors++;
                    $display("%0t: saturated expected %b, got %b", $time, want.saturated,
                             got.saturated);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DW-2:0]        cfg_wdata;
    logic                 hold_req;
    int                   cycle_count = 0;
    flux_scoreboard       sb = new();

    uff_face_if #(.DATA_WIDTH(DW)) face_ch ();
    uff_flux_if #(.DATA_WIDTH(DW)) flux_ch ();

    upwind_face_flux #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .face      (face_ch),
        .result    (flux_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function face_t face_on_bus();
        return face_t'{face_ch.vel_left, face_ch.vel_right, face_ch.phi_m3, face_ch.phi_m2,
                       face_ch.phi_m1, face_ch.phi_left, face_ch.phi_right, face_ch.phi_p1,
                       face_ch.phi_p2, face_ch.phi_p3, face_ch.mu_left, face_ch.mu_right};
    endfunction

    // handshake monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n && face_ch.valid && face_ch.ready)
            sb.note_face(face_on_bus());
        if (rst_n && flux_ch.valid && flux_ch.ready)
            sb.check_flux(flux_t'{flux_ch.face_flux, flux_ch.saturated});
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("upwind_face_flux: mismatch");
            $finish;
        end
    end

    // receiver: stall rate changes per segment, plus one long hold-off on request
    initial
    begin
        int stall_pct;
        int seg_left;
        stall_pct     = 0;
        seg_left      = 0;
        flux_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                flux_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(32, 256);
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                flux_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-2:0] data);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        if (idx == CFG_UPWIND_ORDER)
            sb.cfg_order = data[ORDER_W-1:0];
        else if (idx == CFG_MOBILITY)
            sb.cfg_mob = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending_flux.size() != 0)
            @(negedge clk);
    endtask

    // offer one word from a falling edge and hold it until taken
    task automatic send_face(input face_t w);
        face_ch.valid = 1'b1;
        {face_ch.vel_left, face_ch.vel_right, face_ch.phi_m3, face_ch.phi_m2, face_ch.phi_m1,
         face_ch.phi_left, face_ch.phi_right, face_ch.phi_p1, face_ch.phi_p2, face_ch.phi_p3,
         face_ch.mu_left, face_ch.mu_right} = w;
        do
            @(posedge clk);
        while (!face_ch.ready);
        @(negedge clk);
    endtask

    function face_t directed_face(int k);
        case (k)
            0:       return '0;
            1:       return face_t'({12{Q_MAX}});
            2:       return face_t'({12{Q_MIN}});
            // velocities cancel: zero face velocity, left side upwind
            3:       return face_t'{32'h0100_0000, 32'hff00_0000, 32'hfd00_0000, 32'hfe00_0000,
                                    32'hff00_0000, 32'h0040_0000, 32'h00c0_0000, 32'h0200_0000,
                                    32'h0300_0000, 32'h0400_0000, 32'h0040_0000, 32'h0080_0000};
            // mean of -1 and 0 floors to -1: right side upwind
            4:       return face_t'{32'hffff_ffff, 32'h0000_0000, 32'h1234_5678, 32'hedcb_a988,
                                    32'h7000_0000, 32'h8800_0000, 32'h0000_0001, 32'hffff_ffff,
                                    32'h4000_0000, 32'hc000_0000, Q_MAX, Q_MIN};
            default: return face_t'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                    Q_MAX, Q_MIN, Q_MIN, Q_MAX};
        endcase
    endfunction

    function logic [DW-1:0] small_q(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    function logic [DW-1:0] corner_q();
        case ($urandom_range(5))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return '1;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    // field 11 is vel_left down to field 0 mu_right
    function face_t random_face();
        logic [11:0][DW-1:0] v;
        int                  style;
        int                  i;
        style = $urandom_range(99);
        for (i = 0; i < 12; i++)
        begin
            if (style < 40)
                v[i] = $urandom;
            else if (style < 75)
                v[i] = small_q(i >= 10 ? 32'h0020_0000 : (i >= 2 ? 32'h0100_0000 : 32'h0080_0000));
            else
                v[i] = corner_q();
        end
        // face velocity near zero now and then
        if (style >= 40 && style < 75 && $urandom_range(7) == 0)
            v[10] = -v[11] - $urandom_range(1);
        return face_t'(v);
    endfunction

    task automatic random_config();
        logic [ORDER_W-1:0] ord;
        logic [DW-2:0]      data;
        case ($urandom_range(3))
            0:       ord = ORD_FIRST;
            1:       ord = ORD_THIRD;
            2:       ord = ORD_SEVENTH;
            default: ord = ORD_SPARE;
        endcase
        // upper bits of the order word are don't-care; set them sometimes
        data = (DW-1)'($urandom);
        data[ORDER_W-1:0] = ord;
        if ($urandom_range(3) != 0)
            data[DW-2:ORDER_W] = '0;
        write_reg(CFG_UPWIND_ORDER, data);
        case ($urandom_range(4))
            0:       data = '0;
            1:       data = MOB_MAX;
            2:       data = (DW-1)'($urandom_range(MOB_ONE));
            default: data = (DW-1)'($urandom);
        endcase
        write_reg(CFG_MOBILITY, data);
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, (DW-1)'($urandom));
    endtask

    // bursts of random length with random gaps, no gaps when gap_max is zero
    task automatic run_phase(input int n, input int gap_max);
        int burst;
        int gap;
        int i;
        burst = $urandom_range(1, 40);
        for (i = 0; i < n; i++)
        begin
            send_face(random_face());
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap   = (gap_max > 0) ? $urandom_range(gap_max) : 0;
                if (gap > 0)
                begin
                    face_ch.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        face_ch.valid = 1'b0;
    endtask

    // main sequence
    initial
    begin
        logic [ORDER_W-1:0] ord_list [3];
        int                 i;
        int                 k;
        int                 n;
        int                 sent;
        int                 phase;
        ord_list  = '{ORD_THIRD, ORD_SEVENTH, ORD_SPARE};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_UPWIND_ORDER;
        cfg_wdata = '0;
        hold_req  = 1'b0;
        face_ch.valid = 1'b0;
        {face_ch.vel_left, face_ch.vel_right, face_ch.phi_m3, face_ch.phi_m2, face_ch.phi_m1,
         face_ch.phi_left, face_ch.phi_right, face_ch.phi_p1, face_ch.phi_p2, face_ch.phi_p3,
         face_ch.mu_left, face_ch.mu_right} = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // corner words at reset settings, then under each other order code
        for (k = 0; k < 6; k++)
            send_face(directed_face(k));
        face_ch.valid = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            wait_idle();
            write_reg(CFG_UPWIND_ORDER, ord_list[i]);
            write_reg(CFG_MOBILITY, (ord_list[i] == ORD_SEVENTH) ? MOB_ONE : MOB_MAX);
            if (ord_list[i] == ORD_SPARE)
            begin
                write_reg(CFG_SPARE_LO, '1);
                write_reg(CFG_SPARE_HI, '1);
            end
            for (k = 0; k < 6; k++)
                send_face(directed_face(k));
            face_ch.valid = 1'b0;
        end

        // random phases, each started from an empty pipe with new settings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            n = $urandom_range(30, 70);
            wait_idle();
            random_config();
            if (phase == HOLD_PHASE)
            begin
                hold_req = 1'b1;
                run_phase(n, 0);
            end
            else
                run_phase(n, ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10));
            sent += n;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("upwind_face_flux: match");
        else
            $display("upwind_face_flux: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/uff_pkg.sv
design/uff_face_if.sv
design/uff_stencil.sv
design/uff_phi.sv
design/uff_combine.sv
design/upwind_face_flux.sv
design/upwind_face_flux_chk.sv
dv/upwind_face_flux_test.sv
